FILE: hw/rtl/sha_pkg.sv
// SHA-256 hasher package: types, round constants, a rotate helper function.
package sha_pkg;

    // Front-to-back command word.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_EMIT
    } t_state;

    localparam logic [31:0] C_INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] C_ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] C_PAD_BYTE = 8'h80;

    function automatic logic [31:0] ror(input logic [31:0] v, input int s);
        ror = (v >> s) | (v << (32 - s));
    endfunction

endpackage

FILE: hw/rtl/sha_front.sv
// Front end: input word capture and two-entry command queue.
module sha_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  sha_pkg::t_cmd  i_cmd,
    output logic           o_valid,
    input  logic           i_ready,
    output sha_pkg::t_cmd  o_cmd
);
    sha_pkg::t_cmd r_mem [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

FILE: hw/rtl/sha_core.sv
// Back end: block packing, padding, 64-round compression, digest output.
module sha_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  sha_pkg::t_cmd  i_cmd,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [31:0]    o_word,
    output logic [2:0]     o_index,
    output logic           o_last
);
    sha_pkg::t_state r_state, n_state;
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];
    logic [5:0]  r_pos;
    logic [63:0] r_bits;
    logic [5:0]  r_rnd;
    logic [2:0]  r_idx;
    logic        r_fin;     // compression belongs to the end of a message
    logic        r_lenblk;  // current compression is the length block
    logic        r_mark;    // 0x80 marker still to be written

    logic        w_take;
    logic        w_round_last;
    logic [31:0] w_t1, w_t2, w_s0, w_s1, w_wnew;
    logic [3:0]  w_wi;
    logic [1:0]  w_sh;
    logic [31:0] w_cur, w_mask, w_ins;
    logic [7:0]  w_byte;
    logic        w_pad_full;

    assign w_take       = (r_state == sha_pkg::ST_IDLE) && i_valid;
    assign o_ready      = (r_state == sha_pkg::ST_IDLE);
    assign w_round_last = (r_rnd == 6'd63);

    // round datapath
    assign w_t1 = r_v[7] + (sha_pkg::ror(r_v[4], 6) ^ sha_pkg::ror(r_v[4], 11)
                  ^ sha_pkg::ror(r_v[4], 25))
                  + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
                  + sha_pkg::C_ROUND_K[r_rnd] + r_w[0];
    assign w_t2 = (sha_pkg::ror(r_v[0], 2) ^ sha_pkg::ror(r_v[0], 13)
                  ^ sha_pkg::ror(r_v[0], 22))
                  + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    // schedule as a 16-word shift line
    assign w_s0 = sha_pkg::ror(r_w[1], 7) ^ sha_pkg::ror(r_w[1], 18) ^ (r_w[1] >> 3);
    assign w_s1 = sha_pkg::ror(r_w[14], 17) ^ sha_pkg::ror(r_w[14], 19) ^ (r_w[14] >> 10);
    assign w_wnew = r_w[0] + w_s0 + r_w[9] + w_s1;

    // byte insertion (message byte in IDLE, marker/zero bytes in PAD)
    assign w_wi   = r_pos[5:2];
    assign w_sh   = 2'd3 - r_pos[1:0];
    assign w_cur  = r_w[w_wi];
    assign w_mask = ~(32'hFF << {w_sh, 3'b000});
    assign w_byte = (r_state == sha_pkg::ST_IDLE) ? i_cmd.data_byte :
                    (r_mark ? sha_pkg::C_PAD_BYTE : 8'h00);
    assign w_ins  = (w_cur & w_mask) | ({24'h0, w_byte} << {w_sh, 3'b000});
    assign w_pad_full = (r_pos == 6'd56) && !r_mark;

    always_comb begin
        n_state = r_state;
        case (r_state)
            sha_pkg::ST_IDLE: begin
                if (w_take) begin
                    if (i_cmd.has_byte && r_pos == 6'd63) n_state = sha_pkg::ST_ROUND;
                    else if (i_cmd.end_of_message)       n_state = sha_pkg::ST_PAD;
                end
            end
            sha_pkg::ST_ROUND: if (w_round_last) n_state = sha_pkg::ST_ADD;
            sha_pkg::ST_ADD: begin
                if (r_lenblk)   n_state = sha_pkg::ST_EMIT;
                else if (r_fin) n_state = sha_pkg::ST_PAD;
                else            n_state = sha_pkg::ST_IDLE;
            end
            sha_pkg::ST_PAD: begin
                if (r_pos == 6'd63 || w_pad_full) n_state = sha_pkg::ST_ROUND;
            end
            sha_pkg::ST_EMIT: begin
                if (i_ready && r_idx == 3'd7) n_state = sha_pkg::ST_IDLE;
            end
            default: n_state = sha_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_valid = (r_state == sha_pkg::ST_EMIT);
        o_word  = r_h[r_idx];
        o_index = r_idx;
        o_last  = (r_idx == 3'd7);
    end

    always_ff @(posedge i_clk) begin
        // payload: block words and working variables
        case (r_state)
            sha_pkg::ST_IDLE: begin
                if (w_take && i_cmd.has_byte) r_w[w_wi] <= w_ins;
                for (int k = 0; k < 8; k++) r_v[k] <= r_h[k];
            end
            sha_pkg::ST_PAD: begin
                if (w_pad_full) begin
                    r_w[14] <= r_bits[63:32];
                    r_w[15] <= r_bits[31:0];
                end else begin
                    r_w[w_wi] <= w_ins;
                end
                for (int k = 0; k < 8; k++) r_v[k] <= r_h[k];
            end
            sha_pkg::ST_ROUND: begin
                for (int k = 0; k < 15; k++) r_w[k] <= r_w[k+1];
                r_w[15] <= w_wnew;
                r_v[7] <= r_v[6];
                r_v[6] <= r_v[5];
                r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + w_t1;
                r_v[3] <= r_v[2];
                r_v[2] <= r_v[1];
                r_v[1] <= r_v[0];
                r_v[0] <= w_t1 + w_t2;
            end
            default: ;
        endcase

        if (!i_rst_n) begin
            r_state  <= sha_pkg::ST_IDLE;
            for (int k = 0; k < 8; k++) r_h[k] <= sha_pkg::C_INIT_HASH[k];
            r_pos    <= 6'd0;
            r_bits   <= 64'd0;
            r_rnd    <= 6'd0;
            r_idx    <= 3'd0;
            r_fin    <= 1'b0;
            r_lenblk <= 1'b0;
            r_mark   <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                sha_pkg::ST_IDLE: begin
                    if (w_take) begin
                        r_fin    <= i_cmd.end_of_message;
                        r_mark   <= i_cmd.end_of_message;
                        r_lenblk <= 1'b0;
                        if (i_cmd.has_byte) begin
                            r_pos  <= r_pos + 6'd1;
                            r_bits <= r_bits + 64'd8;
                        end
                    end
                end
                sha_pkg::ST_ROUND: r_rnd <= r_rnd + 6'd1;
                sha_pkg::ST_ADD: begin
                    for (int k = 0; k < 8; k++) r_h[k] <= r_h[k] + r_v[k];
                end
                sha_pkg::ST_PAD: begin
                    if (w_pad_full) begin
                        r_pos    <= 6'd0;
                        r_lenblk <= 1'b1;
                    end else begin
                        r_pos  <= r_pos + 6'd1;
                        r_mark <= 1'b0;
                    end
                end
                sha_pkg::ST_EMIT: begin
                    if (i_ready) begin
                        r_idx <= r_idx + 3'd1;
                        if (r_idx == 3'd7) begin
                            for (int k = 0; k < 8; k++) r_h[k] <= sha_pkg::C_INIT_HASH[k];
                            r_bits <= 64'd0;
                            r_fin  <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

FILE: hw/rtl/sha256_message_hasher_unit.sv
// Top level of the SHA-256 message hasher.
//
//  channel | dir | fields (tdata / tuser, low bit up)
//  s_axis  | in  | tdata[7:0] data_byte; tuser[0] has_byte; tlast end_of_message
//  m_axis  | out | tdata[31:0] digest_word; tuser[2:0] word_index; tlast last_word
//
// A byte word is written into the block when taken; a full block then runs
// 64 rounds and an add step on the single round unit. The end word pads one byte
// per cycle, compresses one or two blocks, then gives eight digest words.
// Reset is synchronous and active low and restores the initial hash.
// A two-entry queue decouples intake from the core; a stall on the output
// holds the core in its emit state.
module sha256_message_hasher_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tuser,   // has_byte
    input  logic        s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // digest_word
    output logic [2:0]  m_axis_tuser,   // word_index
    output logic        m_axis_tlast    // last_word
);
    sha_pkg::t_cmd w_in_cmd, w_q_cmd;
    logic          w_q_valid, w_core_ready;

    assign w_in_cmd = '{data_byte: s_axis_tdata, has_byte: s_axis_tuser,
                        end_of_message: s_axis_tlast};

    sha_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_cmd   (w_in_cmd),
        .o_valid (w_q_valid),
        .i_ready (w_core_ready),
        .o_cmd   (w_q_cmd)
    );

    // The core appends the 0x80 marker itself when it starts padding.
    sha_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .o_ready (w_core_ready),
        .i_cmd   (w_q_cmd),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_word  (m_axis_tdata),
        .o_index (m_axis_tuser),
        .o_last  (m_axis_tlast)
    );
endmodule

FILE: test/tb_top.sv
// Testbench for the SHA-256 message hasher: directed table, then random messages.
module tb_top;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // data_byte
    logic        s_axis_tuser;   // has_byte
    logic        s_axis_tlast;   // end_of_message
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // digest_word
    logic [2:0]  m_axis_tuser;   // word_index
    logic        m_axis_tlast;   // last_word

    sha256_message_hasher_unit uut (.*);

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_digest_out;

    // Predictor state
    logic [31:0] pr_hash [8];
    logic [31:0] pr_block [16];
    logic [5:0]  pr_pos;
    logic [63:0] pr_bits;

    t_digest_out   digest_q [$];
    sha_pkg::t_cmd word_q [$];
    int            n_err;
    int            n_cycles;
    bit            hold_off;

    function automatic logic [31:0] rotr(logic [31:0] v, int s);
        return (v >> s) | (v << (32 - s));
    endfunction

    task automatic pr_compress();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, x, y;
        for (int t = 0; t < 16; t++) w[t] = pr_block[t];
        for (int t = 16; t < 64; t++) begin
            x = w[t-15];
            y = w[t-2];
            w[t] = w[t-16] + (rotr(x,7) ^ rotr(x,18) ^ (x >> 3)) + w[t-7]
                 + (rotr(y,17) ^ rotr(y,19) ^ (y >> 10));
        end
        for (int t = 0; t < 8; t++) v[t] = pr_hash[t];
        for (int r = 0; r < 64; r++) begin
            t1 = v[7] + (rotr(v[4],6) ^ rotr(v[4],11) ^ rotr(v[4],25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::C_ROUND_K[r] + w[r];
            t2 = (rotr(v[0],2) ^ rotr(v[0],13) ^ rotr(v[0],22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int t = 0; t < 8; t++) pr_hash[t] += v[t];
    endtask

    task automatic pr_put(logic [7:0] b);
        pr_block[pr_pos[5:2]][(3 - pr_pos[1:0]) * 8 +: 8] = b;
        pr_pos++;
    endtask

    task automatic pr_reset();
        for (int i = 0; i < 8; i++) pr_hash[i] = sha_pkg::C_INIT_HASH[i];
        for (int i = 0; i < 16; i++) pr_block[i] = '0;
        pr_pos = '0;
        pr_bits = '0;
    endtask

    // Expected digest words for one accepted input word.
    task automatic predict_digest(sha_pkg::t_cmd c);
        t_digest_out d;
        if (c.has_byte) begin
            pr_put(c.data_byte);
            pr_bits += 64'd8;
            if (pr_pos == 0) pr_compress();
        end
        if (!c.end_of_message) return;
        pr_put(sha_pkg::C_PAD_BYTE);
        if (pr_pos > 56) begin
            while (pr_pos != 0) pr_put(8'h00);
            pr_compress();
        end else if (pr_pos == 0) begin
            pr_compress();
        end
        while (pr_pos < 56) pr_put(8'h00);
        pr_block[14] = pr_bits[63:32];
        pr_block[15] = pr_bits[31:0];
        pr_pos = '0;
        pr_compress();
        for (int i = 0; i < 8; i++) begin
            d.digest_word = pr_hash[i];
            d.word_index  = 3'(i);
            d.last_word   = (i == 7);
            digest_q = {digest_q, d};
        end
        for (int i = 0; i < 8; i++) pr_hash[i] = sha_pkg::C_INIT_HASH[i];
        pr_bits = '0;
    endtask

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // Cycle limit: far above a full run with the hold-off and receiver stalls.
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > 400000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Input side bookkeeping: predict on every accepted word.
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            predict_digest(word_q.pop_front());
    end

    // Output side: compare each accepted digest word against the oldest expectation.
    always @(posedge i_clk) begin
        t_digest_out got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata, m_axis_tuser, m_axis_tlast};
            if (digest_q.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected word %h", got);
            end else begin
                want = digest_q.pop_front();
                if (got !== want) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("mismatch: exp %h/%0d/%b got %h/%0d/%b",
                                 want.digest_word, want.word_index, want.last_word,
                                 got.digest_word, got.word_index, got.last_word);
                end
            end
        end
    end

    // Receiver stall pattern, with a long hold-off when requested.
    always @(posedge i_clk) begin
        if (!i_rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_off)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= (n_cycles % 37 < 25) ? ($urandom_range(0, 3) != 0) : 1'b1;
    end

    // Drive one word and wait for acceptance.
    task automatic send_word(sha_pkg::t_cmd c);
        word_q = {word_q, c};
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c.data_byte;
        s_axis_tuser  <= c.has_byte;
        s_axis_tlast  <= c.end_of_message;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic idle_gap();
        int g;
        g = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (digest_q.size() != 0 || word_q.size() != 0) @(posedge i_clk);
    endtask

    // Directed table: {data_byte, has_byte, end_of_message}
    localparam int N_DIR = 12;
    localparam sha_pkg::t_cmd DIR_TAB [N_DIR] = '{
        '{8'h00, 1'b0, 1'b1},   // empty message
        '{8'h61, 1'b1, 1'b0},   // "abc", byte on end word
        '{8'h62, 1'b1, 1'b0},
        '{8'h63, 1'b1, 1'b1},
        '{8'hff, 1'b1, 1'b0},   // extremes, end with no byte
        '{8'h00, 1'b1, 1'b0},
        '{8'h5a, 1'b0, 1'b0},   // idle word without byte
        '{8'h00, 1'b0, 1'b1},
        '{8'hff, 1'b1, 1'b1},   // one byte message
        '{8'h00, 1'b1, 1'b1},
        '{8'h80, 1'b1, 1'b1},
        '{8'h7f, 1'b0, 1'b1}
    };
    // Empty-string digest, first and last word.
    localparam logic [31:0] C_EMPTY_W0 = 32'he3b0c442;
    localparam logic [31:0] C_EMPTY_W7 = 32'h7852b855;

    // Message of given length with random bytes, end marked per mode.
    task automatic send_message(int len, bit end_with_byte);
        sha_pkg::t_cmd c;
        for (int i = 0; i < len; i++) begin
            c.data_byte      = 8'($urandom);
            c.has_byte       = 1'b1;
            c.end_of_message = end_with_byte && (i == len - 1);
            if ($urandom_range(0, 9) == 0) begin
                c.has_byte       = 1'b0;   // noise word
                c.end_of_message = 1'b0;
                i--;
            end
            send_word(c);
            idle_gap();
        end
        if (!end_with_byte || len == 0) begin
            c.data_byte = 8'($urandom);
            c.has_byte = 1'b0;
            c.end_of_message = 1'b1;
            send_word(c);
        end
    endtask

    initial begin
        n_err = 0;
        n_cycles = 0;
        hold_off = 0;
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tuser = 0;
        s_axis_tlast = 0;
        pr_reset();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < N_DIR; k++) begin
            send_word(DIR_TAB[k]);
            idle_gap();
            if (k == 0) begin
                // Typed-in check of the empty message digest, once predicted.
                wait (word_q.size() == 0);
                if (digest_q.size() != 8 || digest_q[0].digest_word != C_EMPTY_W0 ||
                    digest_q[7].digest_word != C_EMPTY_W7) begin
                    n_err++;
                    $display("empty digest mismatch");
                end
            end
        end
        wait_drain();

        // Long receiver hold-off while the sender keeps offering.
        fork
            begin
                hold_off = 1;
                repeat (300) @(posedge i_clk);
                hold_off = 0;
            end
            begin
                send_message(3, 1);
                send_message(4, 0);
            end
        join
        send_message(2, 0);
        wait_drain();

        // Message that spills its padding into a second block.
        send_message(60, 0);
        for (int k = 0; k < 3; k++)
            send_message($urandom_range(0, 10), $urandom_range(0, 1));
        wait_drain();

        repeat (200) @(posedge i_clk);
        if (n_err == 0 && digest_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
